[hw/rtl/hturn_pkg.sv]
// Package for the heading turn PID unit: action, command and register index codes,
// angle and limit constants, and register reset values.
// No dependencies.
package hturn_pkg;

  localparam logic [1:0] ACT_START  = 2'd0;
  localparam logic [1:0] ACT_SAMPLE = 2'd1;
  localparam logic [1:0] ACT_CANCEL = 2'd2;

  localparam logic [1:0] CMD_NONE  = 2'd0;
  localparam logic [1:0] CMD_DRIVE = 2'd1;
  localparam logic [1:0] CMD_STOP  = 2'd2;

  localparam logic [2:0] REG_GAIN_P    = 3'd0;
  localparam logic [2:0] REG_GAIN_I    = 3'd1;
  localparam logic [2:0] REG_GAIN_D    = 3'd2;
  localparam logic [2:0] REG_SPEED_MAX = 3'd3;
  localparam logic [2:0] REG_SPEED_MIN = 3'd4;
  localparam logic [2:0] REG_TOLERANCE = 3'd5;

  localparam logic [15:0] GAIN_P_RST    = 16'd461;
  localparam logic [15:0] GAIN_I_RST    = 16'd0;
  localparam logic [15:0] GAIN_D_RST    = 16'd26;
  localparam logic [7:0]  SPEED_MAX_RST = 8'd100;
  localparam logic [7:0]  SPEED_MIN_RST = 8'd30;
  localparam logic [14:0] TOLERANCE_RST = 15'd200;

  // Angles in centidegrees.
  localparam logic signed [17:0] FULL_TURN = 18'sd36000;
  localparam logic signed [17:0] HALF_TURN = 18'sd18000;

  // Integral limit in centidegree*ms (100 deg*s).
  localparam logic signed [25:0] INTEG_LIMIT = 26'sd10000000;

  // Scale factors of the PID sum; the speed unit 25600000*dt is split as 1024 * 25000*dt.
  localparam logic signed [21:0] P_SCALE    = 22'sd1000;
  localparam logic signed [21:0] D_SCALE    = 22'sd1000000;
  localparam logic signed [43:0] UNIT_SCALE = 44'sd25000;
  localparam int unsigned        UNIT_SHIFT = 10;

  localparam logic [6:0] DT_MAX = 7'd100;

endpackage

[hw/rtl/heading_turn_pid_unit.sv]
// Heading turn PID unit: top level with the sequencer, shared multiplier and serial divider.
// Depends on hturn_pkg for codes and constants.
//
//  Channel | Ports                                             | Direction
//  --------+---------------------------------------------------+----------
//  in      | in_valid, in_ready, in_action, in_heading,        | input word
//          | in_turn_angle, in_elapsed_ms                      |
//  out     | out_valid, out_ready, out_command, out_left_speed,| result word
//          | out_right_speed, out_heading_error, out_running,  |
//          | out_done_res                                      |
//  cfg     | cfg_we, cfg_index, cfg_wdata                      | register write
//
// One word is worked at a time. Cancel, idle samples and unused codes go straight to the
// output step, a start takes up to three target wrap steps, an arriving sample its wrap and
// tolerance steps, and a driven sample up to two wrap steps, the multiply and add steps around
// the shared 44x22 multiplier, and up to nine restoring divider steps for the speed quotient.
// in_ready is high only while the sequencer is idle. A finished word waits in the output
// register, and the next input word is taken meanwhile; that word holds in its last step
// until the output register is free. Reset is synchronous and clears the turn state and
// restores the register defaults.
module heading_turn_pid_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_action,
  input  logic [15:0]        in_heading,
  input  logic signed [16:0] in_turn_angle,
  input  logic [15:0]        in_elapsed_ms,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_command,
  output logic signed [8:0]  out_left_speed,
  output logic signed [8:0]  out_right_speed,
  output logic signed [15:0] out_heading_error,
  output logic               out_running,
  output logic               out_done_res,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_wdata
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_WRAP  = 4'd1;
  localparam logic [3:0] S_TOL   = 4'd2;
  localparam logic [3:0] S_ERRDT = 4'd3;
  localparam logic [3:0] S_GP    = 4'd4;
  localparam logic [3:0] S_GP1K  = 4'd5;
  localparam logic [3:0] S_GI    = 4'd6;
  localparam logic [3:0] S_SUM   = 4'd7;
  localparam logic [3:0] S_SDT   = 4'd8;
  localparam logic [3:0] S_GD    = 4'd9;
  localparam logic [3:0] S_GD1M  = 4'd10;
  localparam logic [3:0] S_FIN   = 4'd11;
  localparam logic [3:0] S_ABS   = 4'd12;
  localparam logic [3:0] S_DIV   = 4'd13;
  localparam logic [3:0] S_OUT   = 4'd14;

  localparam logic [2:0] K_NOP    = 3'd0;
  localparam logic [2:0] K_START  = 3'd1;
  localparam logic [2:0] K_CANCEL = 3'd2;
  localparam logic [2:0] K_ARRIVE = 3'd3;
  localparam logic [2:0] K_DRIVE  = 3'd4;

  localparam logic [3:0] K_TOP = 4'd8;

  // Configuration registers.
  logic [15:0] gain_p_r, gain_i_r, gain_d_r;
  logic [7:0]  speed_max_r, speed_min_r;
  logic [14:0] tolerance_r;

  // Turn state.
  logic [15:0]        target_r, target_nxt;
  logic signed [15:0] prev_r, prev_nxt;
  logic signed [24:0] integ_r, integ_nxt;
  logic               running_r, running_nxt;
  logic               done_r, done_nxt;

  // Sequencer and datapath.
  logic [3:0]         state_r, state_nxt;
  logic [2:0]         kind_r, kind_nxt;
  logic               start_r, start_nxt;
  logic [6:0]         dt_r, dt_nxt;
  logic signed [17:0] w_r, w_nxt;
  logic signed [53:0] s_r, s_nxt;
  logic signed [53:0] prod_r;
  logic [42:0]        rem_r, rem_nxt;
  logic [21:0]        d_r, d_nxt;
  logic [3:0]         k_r, k_nxt;
  logic [7:0]         q_r, q_nxt;
  logic               ovf_r, ovf_nxt;
  logic               nz_r, nz_nxt;

  // Output register.
  logic               out_valid_r, out_valid_nxt;
  logic [1:0]         o_cmd_r, o_cmd_nxt;
  logic signed [8:0]  o_left_r, o_left_nxt;
  logic signed [8:0]  o_right_r, o_right_nxt;
  logic signed [15:0] o_err_r, o_err_nxt;
  logic               o_run_r, o_run_nxt;
  logic               o_done_r, o_done_nxt;

  // Shared multiplier.
  logic               mul_en;
  logic signed [43:0] mul_a;
  logic signed [21:0] mul_b;
  logic signed [65:0] mul_p;

  logic               in_fire;
  logic signed [15:0] err;
  logic [17:0]        aerr;
  logic signed [16:0] de;
  logic signed [25:0] isum;
  logic signed [24:0] iclamp;
  logic [53:0]        s_abs;
  logic [42:0]        dsh;
  logic [7:0]         min_eff;
  logic [7:0]         speed;
  logic signed [8:0]  speed_s;

  assign in_fire = in_valid && in_ready;
  assign err     = w_r[15:0];
  assign aerr    = w_r[17] ? 18'(-w_r) : w_r;
  assign de      = 17'(err) - 17'(prev_r);
  assign isum    = 26'(integ_r) + $signed(prod_r[25:0]);
  assign s_abs   = s_r[53] ? 54'(-s_r) : s_r;
  assign dsh     = {21'd0, d_r} << k_r;
  assign min_eff = (speed_min_r < speed_max_r) ? speed_min_r : speed_max_r;
  assign mul_p   = mul_a * mul_b;

  always_comb begin
    if (isum > hturn_pkg::INTEG_LIMIT) begin
      iclamp = hturn_pkg::INTEG_LIMIT[24:0];
    end else if (isum < -hturn_pkg::INTEG_LIMIT) begin
      iclamp = 25'(-hturn_pkg::INTEG_LIMIT);
    end else begin
      iclamp = isum[24:0];
    end
  end

  // Speed saturation from the quotient: overflow or at least the maximum gives the maximum,
  // any nonzero sum below the minimum is raised to it.
  always_comb begin
    if (ovf_r || q_r >= speed_max_r) begin
      speed = speed_max_r;
    end else if (nz_r && q_r < min_eff) begin
      speed = min_eff;
    end else begin
      speed = q_r;
    end
    speed_s = $signed({1'b0, speed});
  end

  always_comb begin
    mul_en = 1'b1;
    mul_a  = '0;
    mul_b  = '0;
    case (state_r)
      S_ERRDT: begin
        mul_a = 44'(err);
        mul_b = $signed({15'd0, dt_r});
      end
      S_GP: begin
        mul_a = 44'(err);
        mul_b = $signed({6'd0, gain_p_r});
      end
      S_GP1K: begin
        mul_a = $signed(prod_r[43:0]);
        mul_b = hturn_pkg::P_SCALE;
      end
      S_GI: begin
        mul_a = 44'(integ_r);
        mul_b = $signed({6'd0, gain_i_r});
      end
      S_SDT: begin
        mul_a = $signed(s_r[43:0]);
        mul_b = $signed({15'd0, dt_r});
      end
      S_GD: begin
        mul_a = 44'(de);
        mul_b = $signed({6'd0, gain_d_r});
      end
      S_GD1M: begin
        mul_a = $signed(prod_r[43:0]);
        mul_b = hturn_pkg::D_SCALE;
      end
      S_FIN: begin
        mul_a = hturn_pkg::UNIT_SCALE;
        mul_b = $signed({15'd0, dt_r});
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    kind_nxt      = kind_r;
    start_nxt     = start_r;
    dt_nxt        = dt_r;
    w_nxt         = w_r;
    s_nxt         = s_r;
    rem_nxt       = rem_r;
    d_nxt         = d_r;
    k_nxt         = k_r;
    q_nxt         = q_r;
    ovf_nxt       = ovf_r;
    nz_nxt        = nz_r;
    target_nxt    = target_r;
    prev_nxt      = prev_r;
    integ_nxt     = integ_r;
    running_nxt   = running_r;
    done_nxt      = done_r;
    out_valid_nxt = out_valid_r && !out_ready;
    o_cmd_nxt     = o_cmd_r;
    o_left_nxt    = o_left_r;
    o_right_nxt   = o_right_r;
    o_err_nxt     = o_err_r;
    o_run_nxt     = o_run_r;
    o_done_nxt    = o_done_r;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_elapsed_ms == 16'd0) begin
            dt_nxt = 7'd1;
          end else if (in_elapsed_ms > 16'(hturn_pkg::DT_MAX)) begin
            dt_nxt = hturn_pkg::DT_MAX;
          end else begin
            dt_nxt = in_elapsed_ms[6:0];
          end
          if (in_action == hturn_pkg::ACT_START) begin
            w_nxt     = 18'($signed({1'b0, in_heading})) + 18'(in_turn_angle);
            start_nxt = 1'b1;
            state_nxt = S_WRAP;
          end else if (in_action == hturn_pkg::ACT_SAMPLE && running_r) begin
            w_nxt     = $signed({2'd0, target_r}) - $signed({2'd0, in_heading});
            start_nxt = 1'b0;
            state_nxt = S_WRAP;
          end else if (in_action == hturn_pkg::ACT_CANCEL) begin
            kind_nxt  = K_CANCEL;
            state_nxt = S_OUT;
          end else begin
            kind_nxt  = K_NOP;
            state_nxt = S_OUT;
          end
        end
      end
      S_WRAP: begin
        // The target wraps into 0..35999, the error into -18000..18000, one turn a cycle.
        if (start_r) begin
          if (w_r >= hturn_pkg::FULL_TURN) begin
            w_nxt = w_r - hturn_pkg::FULL_TURN;
          end else if (w_r < 0) begin
            w_nxt = w_r + hturn_pkg::FULL_TURN;
          end else begin
            kind_nxt  = K_START;
            state_nxt = S_OUT;
          end
        end else begin
          if (w_r > hturn_pkg::HALF_TURN) begin
            w_nxt = w_r - hturn_pkg::FULL_TURN;
          end else if (w_r < -hturn_pkg::HALF_TURN) begin
            w_nxt = w_r + hturn_pkg::FULL_TURN;
          end else begin
            state_nxt = S_TOL;
          end
        end
      end
      S_TOL: begin
        if (aerr <= {3'd0, tolerance_r}) begin
          kind_nxt  = K_ARRIVE;
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_ERRDT;
        end
      end
      S_ERRDT: begin
        state_nxt = S_GP;
      end
      S_GP: begin
        integ_nxt = iclamp;
        state_nxt = S_GP1K;
      end
      S_GP1K: begin
        state_nxt = S_GI;
      end
      S_GI: begin
        s_nxt     = prod_r;
        state_nxt = S_SUM;
      end
      S_SUM: begin
        s_nxt     = s_r + prod_r;
        state_nxt = S_SDT;
      end
      S_SDT: begin
        state_nxt = S_GD;
      end
      S_GD: begin
        s_nxt     = prod_r;
        prev_nxt  = err;
        state_nxt = S_GD1M;
      end
      S_GD1M: begin
        state_nxt = S_FIN;
      end
      S_FIN: begin
        s_nxt     = s_r + prod_r;
        state_nxt = S_ABS;
      end
      S_ABS: begin
        // Dividing by 1024 first leaves the divisor 25000*dt with the same floor quotient.
        rem_nxt   = s_abs[52:hturn_pkg::UNIT_SHIFT];
        nz_nxt    = (s_r != '0);
        d_nxt     = prod_r[21:0];
        k_nxt     = K_TOP;
        q_nxt     = '0;
        ovf_nxt   = 1'b0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        // The top step only flags a quotient of 256 or more, which saturates anyway.
        if (rem_r >= dsh) begin
          if (k_r == K_TOP) begin
            ovf_nxt = 1'b1;
          end else begin
            rem_nxt = rem_r - dsh;
            q_nxt   = q_r | (8'd1 << k_r[2:0]);
          end
        end
        if (k_r == 4'd0 || (k_r == K_TOP && rem_r >= dsh)) begin
          kind_nxt  = K_DRIVE;
          state_nxt = S_OUT;
        end else begin
          k_nxt = k_r - 4'd1;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          o_cmd_nxt   = hturn_pkg::CMD_NONE;
          o_left_nxt  = '0;
          o_right_nxt = '0;
          o_err_nxt   = '0;
          case (kind_r)
            K_START: begin
              if (running_r) begin
                o_cmd_nxt = hturn_pkg::CMD_STOP;
              end
              target_nxt  = w_r[15:0];
              prev_nxt    = '0;
              integ_nxt   = '0;
              running_nxt = 1'b1;
              done_nxt    = 1'b0;
            end
            K_CANCEL: begin
              if (running_r) begin
                o_cmd_nxt   = hturn_pkg::CMD_STOP;
                prev_nxt    = '0;
                integ_nxt   = '0;
                running_nxt = 1'b0;
                done_nxt    = 1'b0;
              end
            end
            K_ARRIVE: begin
              o_cmd_nxt   = hturn_pkg::CMD_STOP;
              o_err_nxt   = err;
              prev_nxt    = '0;
              integ_nxt   = '0;
              running_nxt = 1'b0;
              done_nxt    = 1'b1;
            end
            K_DRIVE: begin
              o_cmd_nxt = hturn_pkg::CMD_DRIVE;
              o_err_nxt = err;
              if (err > 0) begin
                o_left_nxt  = -speed_s;
                o_right_nxt = speed_s;
              end else begin
                o_left_nxt  = speed_s;
                o_right_nxt = -speed_s;
              end
            end
            default: begin
            end
          endcase
          o_run_nxt     = running_nxt;
          o_done_nxt    = done_nxt;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      target_r    <= '0;
      prev_r      <= '0;
      integ_r     <= '0;
      running_r   <= 1'b0;
      done_r      <= 1'b0;
      gain_p_r    <= hturn_pkg::GAIN_P_RST;
      gain_i_r    <= hturn_pkg::GAIN_I_RST;
      gain_d_r    <= hturn_pkg::GAIN_D_RST;
      speed_max_r <= hturn_pkg::SPEED_MAX_RST;
      speed_min_r <= hturn_pkg::SPEED_MIN_RST;
      tolerance_r <= hturn_pkg::TOLERANCE_RST;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      target_r    <= target_nxt;
      prev_r      <= prev_nxt;
      integ_r     <= integ_nxt;
      running_r   <= running_nxt;
      done_r      <= done_nxt;
      if (cfg_we) begin
        case (cfg_index)
          hturn_pkg::REG_GAIN_P:    gain_p_r    <= cfg_wdata;
          hturn_pkg::REG_GAIN_I:    gain_i_r    <= cfg_wdata;
          hturn_pkg::REG_GAIN_D:    gain_d_r    <= cfg_wdata;
          hturn_pkg::REG_SPEED_MAX: speed_max_r <= cfg_wdata[7:0];
          hturn_pkg::REG_SPEED_MIN: speed_min_r <= cfg_wdata[7:0];
          hturn_pkg::REG_TOLERANCE: tolerance_r <= cfg_wdata[14:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    kind_r    <= kind_nxt;
    start_r   <= start_nxt;
    dt_r      <= dt_nxt;
    w_r       <= w_nxt;
    s_r       <= s_nxt;
    rem_r     <= rem_nxt;
    d_r       <= d_nxt;
    k_r       <= k_nxt;
    q_r       <= q_nxt;
    ovf_r     <= ovf_nxt;
    nz_r      <= nz_nxt;
    o_cmd_r   <= o_cmd_nxt;
    o_left_r  <= o_left_nxt;
    o_right_r <= o_right_nxt;
    o_err_r   <= o_err_nxt;
    o_run_r   <= o_run_nxt;
    o_done_r  <= o_done_nxt;
    if (mul_en) begin
      prod_r <= mul_p[53:0];
    end
  end

  assign in_ready          = (state_r == S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_command       = o_cmd_r;
  assign out_left_speed    = o_left_r;
  assign out_right_speed   = o_right_r;
  assign out_heading_error = o_err_r;
  assign out_running       = o_run_r;
  assign out_done_res      = o_done_r;

endmodule

[tb/heading_turn_pid_checker.sv]
// Checker for the heading turn PID unit: watches the input, result and register write ports,
// predicts every result word and compares it with what the block returns.
// Depends on hturn_pkg for the action, command and register codes and the reset values.
`timescale 1ns / 100ps

module heading_turn_pid_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [1:0]         in_action,
  input  logic [15:0]        in_heading,
  input  logic signed [16:0] in_turn_angle,
  input  logic [15:0]        in_elapsed_ms,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [1:0]         out_command,
  input  logic signed [8:0]  out_left_speed,
  input  logic signed [8:0]  out_right_speed,
  input  logic signed [15:0] out_heading_error,
  input  logic               out_running,
  input  logic               out_done_res,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_wdata,
  output int                 mismatches,
  output int                 outstanding
);

  typedef struct packed {
    logic [1:0]         command;
    logic signed [8:0]  left_speed;
    logic signed [8:0]  right_speed;
    logic signed [15:0] heading_error;
    logic               running;
    logic               done_res;
  } turn_word_t;

  localparam int ANGLE_FULL  = 36000;
  localparam int ANGLE_HALF  = 18000;
  localparam int ACC_LIMIT   = 10000000;
  localparam longint UNIT_PER_MS = 64'sd25600000;

  // Predicted controller state and register copies.
  int target_hdg, last_err, integ_acc;
  bit turning, arrived;
  int kp, ki, kd, vmax, vmin, tol;

  turn_word_t expected_words[$];

  task automatic restore_defaults();
    kp = hturn_pkg::GAIN_P_RST;
    ki = hturn_pkg::GAIN_I_RST;
    kd = hturn_pkg::GAIN_D_RST;
    vmax = hturn_pkg::SPEED_MAX_RST;
    vmin = hturn_pkg::SPEED_MIN_RST;
    tol = hturn_pkg::TOLERANCE_RST;
    target_hdg = 0;
    last_err = 0;
    integ_acc = 0;
    turning = 1'b0;
    arrived = 1'b0;
  endtask

  function automatic turn_word_t predict_turn(input logic [1:0] act, input logic [15:0] hdg,
                                              input logic signed [16:0] turn,
                                              input logic [15:0] ms);
    turn_word_t w;
    int t, e, ae, dt, acc, v, min_eff;
    longint de, s, mag, unit;
    w = '0;
    if (act == hturn_pkg::ACT_START) begin
      w.command = turning ? hturn_pkg::CMD_STOP : hturn_pkg::CMD_NONE;
      t = (int'(hdg) + int'(turn)) % ANGLE_FULL;
      if (t < 0) t += ANGLE_FULL;
      target_hdg = t;
      last_err = 0;
      integ_acc = 0;
      arrived = 1'b0;
      turning = 1'b1;
    end else if (act == hturn_pkg::ACT_CANCEL) begin
      if (turning) begin
        turning = 1'b0;
        arrived = 1'b0;
        last_err = 0;
        integ_acc = 0;
        w.command = hturn_pkg::CMD_STOP;
      end
    end else if (act == hturn_pkg::ACT_SAMPLE && turning) begin
      e = target_hdg - int'(hdg);
      while (e > ANGLE_HALF) e -= ANGLE_FULL;
      while (e < -ANGLE_HALF) e += ANGLE_FULL;
      ae = (e < 0) ? -e : e;
      w.heading_error = 16'(e);
      if (ae <= tol) begin
        turning = 1'b0;
        arrived = 1'b1;
        last_err = 0;
        integ_acc = 0;
        w.command = hturn_pkg::CMD_STOP;
      end else begin
        dt = int'(ms);
        if (dt == 0) dt = 1;
        if (dt > 100) dt = 100;
        acc = integ_acc + e * dt;
        if (acc > ACC_LIMIT) acc = ACC_LIMIT;
        if (acc < -ACC_LIMIT) acc = -ACC_LIMIT;
        integ_acc = acc;
        de = longint'(e) - longint'(last_err);
        last_err = e;
        s = (longint'(kp) * e * 1000 + longint'(ki) * acc) * dt
            + longint'(kd) * de * 1000000;
        mag = (s < 0) ? -s : s;
        unit = UNIT_PER_MS * dt;
        min_eff = (vmin < vmax) ? vmin : vmax;
        if (mag >= longint'(vmax) * unit) v = vmax;
        else if (mag > 0 && mag < longint'(min_eff) * unit) v = min_eff;
        else v = int'(mag / unit);
        w.command = hturn_pkg::CMD_DRIVE;
        // Positive error drives the left wheel backward and the right wheel forward.
        if (e > 0) begin
          w.left_speed = 9'(-v);
          w.right_speed = 9'(v);
        end else begin
          w.left_speed = 9'(v);
          w.right_speed = 9'(-v);
        end
      end
    end
    w.running = turning;
    w.done_res = arrived;
    return w;
  endfunction

  task automatic check_field(input string label, input logic signed [31:0] want_v,
                             input logic signed [31:0] got_v);
    if (got_v !== want_v) begin
      mismatches++;
      $display("%0t: %s expected %0d actual %0d", $time, label, want_v, got_v);
    end
  endtask

  always @(posedge clk) begin
    turn_word_t want;
    if (!rst_n) begin
      restore_defaults();
      expected_words.delete();
      mismatches = 0;
      outstanding <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          hturn_pkg::REG_GAIN_P:    kp = cfg_wdata;
          hturn_pkg::REG_GAIN_I:    ki = cfg_wdata;
          hturn_pkg::REG_GAIN_D:    kd = cfg_wdata;
          hturn_pkg::REG_SPEED_MAX: vmax = cfg_wdata[7:0];
          hturn_pkg::REG_SPEED_MIN: vmin = cfg_wdata[7:0];
          hturn_pkg::REG_TOLERANCE: tol = cfg_wdata[14:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        expected_words.push_back(predict_turn(in_action, in_heading, in_turn_angle,
                                              in_elapsed_ms));
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          mismatches++;
          $display("%0t: result word expected none actual command %0d", $time, out_command);
        end else begin
          want = expected_words.pop_front();
          check_field("command", want.command, out_command);
          check_field("left_speed", want.left_speed, out_left_speed);
          check_field("right_speed", want.right_speed, out_right_speed);
          check_field("heading_error", want.heading_error, out_heading_error);
          check_field("running", want.running, out_running);
          check_field("done_res", want.done_res, out_done_res);
        end
      end
      outstanding <= expected_words.size();
    end
  end

endmodule

[tb/heading_turn_pid_unit_test.sv]
// Top of the heading turn PID unit testbench: clock, reset, directed and random turn
// sequences, register settings, handshake idling and the final verdict.
// Depends on hturn_pkg, heading_turn_pid_unit and heading_turn_pid_checker.
`timescale 1ns / 100ps

module heading_turn_pid_unit_test;

  localparam logic [1:0] ACT_UNUSED    = 2'd3;
  localparam logic [2:0] REG_UNUSED_LO = 3'd6;
  localparam logic [2:0] REG_UNUSED_HI = 3'd7;
  localparam int QUIET_LIMIT = 3000;
  localparam int PHASE_WORDS = 165;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [1:0]         in_action = '0;
  logic [15:0]        in_heading = '0;
  logic signed [16:0] in_turn_angle = '0;
  logic [15:0]        in_elapsed_ms = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [1:0]         out_command;
  logic signed [8:0]  out_left_speed;
  logic signed [8:0]  out_right_speed;
  logic signed [15:0] out_heading_error;
  logic               out_running;
  logic               out_done_res;
  logic               cfg_we = 1'b0;
  logic [2:0]         cfg_index = '0;
  logic [15:0]        cfg_wdata = '0;

  int mismatches, outstanding;
  int sender_idle = 0;
  int receiver_stall = 0;
  int words_sent = 0;
  int quiet_cycles = 0;

  heading_turn_pid_unit u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_action(in_action),
    .in_heading(in_heading), .in_turn_angle(in_turn_angle), .in_elapsed_ms(in_elapsed_ms),
    .out_valid(out_valid), .out_ready(out_ready), .out_command(out_command),
    .out_left_speed(out_left_speed), .out_right_speed(out_right_speed),
    .out_heading_error(out_heading_error), .out_running(out_running),
    .out_done_res(out_done_res),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  heading_turn_pid_checker u_check (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_action(in_action),
    .in_heading(in_heading), .in_turn_angle(in_turn_angle), .in_elapsed_ms(in_elapsed_ms),
    .out_valid(out_valid), .out_ready(out_ready), .out_command(out_command),
    .out_left_speed(out_left_speed), .out_right_speed(out_right_speed),
    .out_heading_error(out_heading_error), .out_running(out_running),
    .out_done_res(out_done_res),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .mismatches(mismatches), .outstanding(outstanding)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= receiver_stall);
  end

  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Presents one input word after a random gap and returns at a clock edge once in_ready reads high.
  task automatic send_word(input logic [1:0] act, input logic [15:0] hdg,
                           input logic signed [16:0] turn, input logic [15:0] ms);
    while ($urandom_range(99) < sender_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_action <= act;
    in_heading <= hdg;
    in_turn_angle <= turn;
    in_elapsed_ms <= ms;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
  endtask

  // Holds the sender off until every result word is back and the block has gone idle.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_put(input logic [2:0] idx, input logic [15:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
  endtask

  task automatic apply_settings(input int phase);
    case (phase)
      0: begin
        cfg_put(hturn_pkg::REG_GAIN_P, hturn_pkg::GAIN_P_RST);
        cfg_put(hturn_pkg::REG_GAIN_I, hturn_pkg::GAIN_I_RST);
        cfg_put(hturn_pkg::REG_GAIN_D, hturn_pkg::GAIN_D_RST);
        cfg_put(hturn_pkg::REG_SPEED_MAX, 16'(hturn_pkg::SPEED_MAX_RST));
        cfg_put(hturn_pkg::REG_SPEED_MIN, 16'(hturn_pkg::SPEED_MIN_RST));
        cfg_put(hturn_pkg::REG_TOLERANCE, 16'(hturn_pkg::TOLERANCE_RST));
      end
      1: begin
        cfg_put(hturn_pkg::REG_GAIN_P, 16'hFFFF);
        cfg_put(hturn_pkg::REG_GAIN_I, 16'hFFFF);
        cfg_put(hturn_pkg::REG_GAIN_D, 16'hFFFF);
        cfg_put(hturn_pkg::REG_SPEED_MAX, 16'hFFFF);
        cfg_put(hturn_pkg::REG_SPEED_MIN, 16'h0000);
        cfg_put(hturn_pkg::REG_TOLERANCE, 16'd18000);
      end
      2: begin
        // Upper bits of the speed maximum and tolerance registers are set and must be dropped.
        cfg_put(hturn_pkg::REG_GAIN_P, 16'h0000);
        cfg_put(hturn_pkg::REG_GAIN_I, 16'h0000);
        cfg_put(hturn_pkg::REG_GAIN_D, 16'h0000);
        cfg_put(hturn_pkg::REG_SPEED_MAX, 16'hFF01);
        cfg_put(hturn_pkg::REG_SPEED_MIN, 16'h00FF);
        cfg_put(hturn_pkg::REG_TOLERANCE, 16'h8001);
      end
      3: begin
        // Zero tolerance: only an exact hit counts as arrival.
        cfg_put(hturn_pkg::REG_GAIN_P, 16'($urandom_range(2000)));
        cfg_put(hturn_pkg::REG_GAIN_I, 16'($urandom_range(300)));
        cfg_put(hturn_pkg::REG_GAIN_D, 16'($urandom_range(500)));
        cfg_put(hturn_pkg::REG_SPEED_MAX, 16'($urandom_range(1, 255)));
        cfg_put(hturn_pkg::REG_SPEED_MIN, 16'($urandom_range(255)));
        cfg_put(hturn_pkg::REG_TOLERANCE, 16'h0000);
      end
      4: begin
        cfg_put(hturn_pkg::REG_GAIN_P, 16'($urandom));
        cfg_put(hturn_pkg::REG_GAIN_I, 16'($urandom));
        cfg_put(hturn_pkg::REG_GAIN_D, 16'($urandom));
        cfg_put(hturn_pkg::REG_SPEED_MAX, 16'($urandom));
        cfg_put(hturn_pkg::REG_SPEED_MIN, 16'($urandom));
        cfg_put(hturn_pkg::REG_TOLERANCE, 16'($urandom) & 16'h8FFF);
        cfg_put(REG_UNUSED_LO, 16'($urandom));
        cfg_put(REG_UNUSED_HI, 16'($urandom));
      end
      default: begin
        cfg_put(hturn_pkg::REG_GAIN_P, 16'd1024);
        cfg_put(hturn_pkg::REG_GAIN_I, 16'd512);
        cfg_put(hturn_pkg::REG_GAIN_D, 16'd0);
        cfg_put(hturn_pkg::REG_SPEED_MAX, 16'd200);
        cfg_put(hturn_pkg::REG_SPEED_MIN, 16'd50);
        cfg_put(hturn_pkg::REG_TOLERANCE, 16'd50);
      end
    endcase
    cfg_we <= 1'b0;
  endtask

  // One well-formed turn: a start, samples closing in on the target, then maybe a
  // cancel or a sample right on the target.
  task automatic run_turn();
    logic [15:0] start_hdg, hdg, ms;
    logic signed [16:0] turn;
    int target, err_now;
    if ($urandom_range(9) == 0) begin
      start_hdg = 16'($urandom);
      turn = 17'($urandom);
    end else begin
      start_hdg = 16'($urandom_range(35999));
      turn = 17'(int'($urandom_range(72000)) - 36000);
    end
    send_word(hturn_pkg::ACT_START, start_hdg, turn, 16'($urandom));
    target = (int'(start_hdg) + int'(turn)) % 36000;
    if (target < 0) target += 36000;
    err_now = int'(turn);
    repeat ($urandom_range(1, 10)) begin
      err_now = err_now * int'($urandom_range(30, 90)) / 100
                + int'($urandom_range(600)) - 300;
      if ($urandom_range(7) == 0) hdg = 16'($urandom);
      else hdg = 16'(((target - err_now) % 36000 + 36000) % 36000);
      case ($urandom_range(9))
        0: ms = 16'd0;
        1: ms = 16'($urandom);
        default: ms = 16'($urandom_range(1, 120));
      endcase
      send_word(hturn_pkg::ACT_SAMPLE, hdg, 17'($urandom), ms);
    end
    case ($urandom_range(5))
      0: send_word(hturn_pkg::ACT_CANCEL, 16'($urandom), 17'($urandom), 16'($urandom));
      1, 2: send_word(hturn_pkg::ACT_SAMPLE, 16'(target), 17'($urandom),
                      16'($urandom_range(1, 100)));
      default: ;
    endcase
  endtask

  initial begin
    int phase, phase_end;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed words with the reset register values.
    send_word(hturn_pkg::ACT_SAMPLE, 16'd1000, 17'sd0, 16'd10);     // sample while idle
    send_word(hturn_pkg::ACT_CANCEL, 16'd0, 17'sd0, 16'd0);         // cancel while idle
    send_word(ACT_UNUSED, 16'hFFFF, 17'sh1FFFF, 16'hFFFF);          // unused action code
    send_word(hturn_pkg::ACT_START, 16'd0, 17'sd36000, 16'd0);
    send_word(hturn_pkg::ACT_START, 16'd35999, -17'sd36000, 16'd0); // restart while running
    send_word(hturn_pkg::ACT_START, 16'hFFFF, 17'sh10000, 16'd0);   // out-of-range inputs
    send_word(hturn_pkg::ACT_START, 16'd0, 17'sd18000, 16'd0);
    send_word(hturn_pkg::ACT_SAMPLE, 16'd0, 17'sd0, 16'd0);         // half turn, zero dt
    send_word(hturn_pkg::ACT_SAMPLE, 16'd36000, 17'sd0, 16'hFFFF);  // negative half, long dt
    send_word(hturn_pkg::ACT_SAMPLE, 16'hFFFF, 17'sd0, 16'd100);
    send_word(hturn_pkg::ACT_SAMPLE, 16'd17000, 17'sd0, 16'd101);
    send_word(hturn_pkg::ACT_SAMPLE, 16'd18200, 17'sd0, 16'd20);    // arrival at band edge
    send_word(hturn_pkg::ACT_SAMPLE, 16'd0, 17'sd0, 16'd20);        // sample after arrival
    send_word(hturn_pkg::ACT_START, 16'd100, 17'sd65535, 16'd0);
    send_word(hturn_pkg::ACT_SAMPLE, 16'd29000, 17'sd0, 16'd50);
    send_word(hturn_pkg::ACT_SAMPLE, 16'd29000, 17'sd0, 16'd1);
    send_word(hturn_pkg::ACT_CANCEL, 16'd0, 17'sd0, 16'd0);         // cancel while running
    send_word(hturn_pkg::ACT_START, 16'd0, 17'sd0, 16'd0);
    send_word(hturn_pkg::ACT_SAMPLE, 16'd0, 17'sd0, 16'd5);         // exact hit
    send_word(hturn_pkg::ACT_START, 16'd9000, -17'sd9001, 16'd0);
    send_word(hturn_pkg::ACT_SAMPLE, 16'd200, 17'sd0, 16'd20);      // just outside the band
    send_word(hturn_pkg::ACT_SAMPLE, 16'd35800, 17'sd0, 16'd20);
    drain();

    for (phase = 0; phase < 6; phase++) begin
      apply_settings(phase);
      case (phase % 4)
        0: begin sender_idle = 0;  receiver_stall = 0;  end
        1: begin sender_idle = 55; receiver_stall = 0;  end
        2: begin sender_idle = 0;  receiver_stall = 55; end
        default: begin sender_idle = 24; receiver_stall = 24; end
      endcase
      phase_end = words_sent + PHASE_WORDS;
      while (words_sent < phase_end) begin
        case ($urandom_range(19))
          0, 1: send_word(2'($urandom), 16'($urandom), 17'($urandom), 16'($urandom));
          2: drain();
          default: run_turn();
        endcase
      end
      drain();
    end

    sender_idle = 0;
    receiver_stall = 0;
    repeat (30) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
